// File: hdl/adrp_pkg.sv
// Shared types and constants of the archive directory record parser.
package adrp_pkg;

    localparam int RECORD_BYTES = 29;
    localparam int SLOT_COUNT   = 3;

    localparam logic [7:0] FLAG_NEW_GROUP = 8'h10;
    localparam logic [7:0] FLAG_END_GROUP = 8'h08;
    localparam logic [7:0] FLAG_RESERVED  = 8'he7;

    typedef struct packed {
        logic [7:0] dir_byte;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [15:0] member_index;
        logic [7:0]  name_char;
        logic [31:0] data_offset;
        logic [31:0] packed_size;
        logic [46:0] skip_size;
        logic [30:0] original_size;
        logic [31:0] timestamp;
        logic [15:0] group_first;
        logic [15:0] member_total;
        logic        last_of_run;
    } result_t;

    typedef struct packed {
        logic [1:0]                   count;
        result_t [SLOT_COUNT-1:0]     slot;
    } res_set_t;

endpackage

// File: hdl/adrp_in_stage.sv
// Input register stage that holds one directory byte for the parser core.
module adrp_in_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    input  logic           s_tlast,
    input  logic           take,
    output logic           item_valid,
    output adrp_pkg::item_t item
);
    import adrp_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_tready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_tvalid && s_tready) begin
            valid_reg <= 1'b1;
        end else if (take) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.dir_byte  <= s_tdata;
            item_reg.last_byte <= s_tlast;
        end
    end

endmodule

// File: hdl/adrp_core.sv
// Parser state, configuration registers and the per-byte result logic.
module adrp_core #(
    parameter int NAME_LIMIT = 1024
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               item_valid,
    input  adrp_pkg::item_t    item,
    input  logic               out_free,
    output logic               take,
    output adrp_pkg::res_set_t res_set
);
    import adrp_pkg::*;

    localparam int NameLenW = $clog2(NAME_LIMIT + 1);
    localparam int PosW     = $clog2(RECORD_BYTES);

    localparam logic [1:0] PH_RECORD  = 2'd0;
    localparam logic [1:0] PH_NAME    = 2'd1;
    localparam logic [1:0] PH_COMMENT = 2'd2;
    localparam logic [1:0] PH_DONE    = 2'd3;

    localparam logic [2:0] KIND_NAME   = 3'd0;
    localparam logic [2:0] KIND_MEMBER = 3'd1;
    localparam logic [2:0] KIND_CLOSE  = 3'd2;
    localparam logic [2:0] KIND_OK     = 3'd3;
    localparam logic [2:0] KIND_FAIL   = 3'd4;

    localparam logic [1:0] CFG_MEMBER_COUNT = 2'd0;
    localparam logic [1:0] CFG_INPUT_SIZE   = 2'd1;
    localparam logic [1:0] CFG_STORED_MODE  = 2'd2;

    logic [15:0] member_count_reg;
    logic [31:0] input_size_reg;
    logic        stored_mode_reg;

    logic [1:0]          phase_reg,  phase_next;
    logic [PosW-1:0]     pos_reg,    pos_next;
    logic [NameLenW-1:0] name_len_reg, name_len_next;
    logic [15:0]         done_reg,   done_next;
    logic                grp_open_reg, grp_open_next;
    logic [30:0]         grp_start_reg, grp_start_next;
    logic [46:0]         grp_skip_reg, grp_skip_next;
    logic [15:0]         grp_first_reg, grp_first_next;
    logic [7:0]          rec_reg [RECORD_BYTES];
    logic                rec_we;

    function automatic result_t blank(input logic [2:0] k, input logic [15:0] idx);
        result_t r;
        r = '0;
        r.kind = k;
        r.member_index = idx;
        return r;
    endfunction

    function automatic result_t status(input logic hard, input logic [15:0] md);
        result_t r;
        r = blank((hard || md == 16'd0) ? KIND_FAIL : KIND_OK, md);
        r.member_total = md;
        return r;
    endfunction

    // Record fields, little endian.
    logic [31:0] f_time, f_orig, f_packed, f_doff;
    logic [7:0]  f_flags;
    assign f_time   = {rec_reg[4],  rec_reg[3],  rec_reg[2],  rec_reg[1]};
    assign f_orig   = {rec_reg[8],  rec_reg[7],  rec_reg[6],  rec_reg[5]};
    assign f_packed = {rec_reg[12], rec_reg[11], rec_reg[10], rec_reg[9]};
    assign f_doff   = {rec_reg[16], rec_reg[15], rec_reg[14], rec_reg[13]};
    assign f_flags  = rec_reg[22];

    // Entry arithmetic, evaluated from the stored record.
    logic        new_grp, open_eff, grp_bad, bad_field, off_over;
    logic [30:0] start_eff;
    logic [46:0] skip_eff;
    logic [15:0] first_eff, done_inc;
    logic [47:0] off_sum;
    logic [31:0] room_stored, room_grp, size_stored, size_close;

    assign new_grp   = (f_flags & FLAG_NEW_GROUP) != 8'd0;
    assign bad_field = f_orig[31] || f_packed[31] || f_doff[31]
                       || ((f_flags & FLAG_RESERVED) != 8'd0);
    assign open_eff  = new_grp || grp_open_reg;
    assign start_eff = new_grp ? f_doff[30:0] : grp_start_reg;
    assign skip_eff  = new_grp ? 47'd0 : grp_skip_reg;
    assign first_eff = new_grp ? done_reg : grp_first_reg;
    assign grp_bad   = !open_eff || ({1'b0, start_eff} > input_size_reg);
    assign off_sum   = {17'd0, start_eff} + {1'b0, skip_eff};
    assign off_over  = off_sum > {16'd0, input_size_reg};
    assign room_stored = input_size_reg - off_sum[31:0];
    assign room_grp    = input_size_reg - {1'b0, start_eff};
    assign size_stored = (f_orig <= room_stored) ? f_orig : room_stored;
    assign size_close  = (f_packed <= room_grp) ? f_packed : room_grp;
    assign done_inc    = done_reg + 16'd1;

    always_comb begin
        res_set_t    rs;
        result_t     m;
        logic [1:0]  n;
        logic        b_zero;

        rs = '0;
        m  = '0;
        n  = 2'd0;
        b_zero = item.dir_byte == 8'd0;

        phase_next     = phase_reg;
        pos_next       = pos_reg;
        name_len_next  = name_len_reg;
        done_next      = done_reg;
        grp_open_next  = grp_open_reg;
        grp_start_next = grp_start_reg;
        grp_skip_next  = grp_skip_reg;
        grp_first_next = grp_first_reg;
        rec_we         = 1'b0;

        unique case (phase_reg)
            PH_RECORD: begin
                if (pos_reg == '0 && done_reg >= member_count_reg) begin
                    rs.slot[0] = status(1'b0, done_reg);
                    n = 2'd1;
                    phase_next = PH_DONE;
                end else begin
                    rec_we = 1'b1;
                    if (item.last_byte) begin
                        rs.slot[0] = status(1'b0, done_reg);
                        n = 2'd1;
                        phase_next = PH_DONE;
                    end else if (pos_reg == PosW'(RECORD_BYTES - 1)) begin
                        phase_next    = PH_NAME;
                        pos_next      = '0;
                        name_len_next = '0;
                    end else begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
            end
            PH_NAME: begin
                if (b_zero) begin
                    if (name_len_reg == '0 || item.last_byte) begin
                        rs.slot[0] = status(1'b0, done_reg);
                        n = 2'd1;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_COMMENT;
                    end
                end else if (name_len_reg == NameLenW'(NAME_LIMIT)) begin
                    // The name runs past the limit: a hard failure.
                    rs.slot[0] = status(1'b1, done_reg);
                    n = 2'd1;
                    phase_next = PH_DONE;
                end else begin
                    name_len_next = name_len_reg + 1'b1;
                    rs.slot[0] = blank(KIND_NAME, done_reg);
                    rs.slot[0].name_char = item.dir_byte;
                    n = 2'd1;
                    if (item.last_byte) begin
                        rs.slot[1] = status(1'b0, done_reg);
                        n = 2'd2;
                        phase_next = PH_DONE;
                    end
                end
            end
            PH_COMMENT: begin
                if (!b_zero || bad_field || grp_bad || (stored_mode_reg && off_over)) begin
                    rs.slot[0] = status(1'b0, done_reg);
                    n = 2'd1;
                    phase_next = PH_DONE;
                end else begin
                    m = blank(KIND_MEMBER, done_reg);
                    m.original_size = f_orig[30:0];
                    m.timestamp     = f_time;
                    if (stored_mode_reg) begin
                        m.data_offset = off_sum[31:0];
                        m.packed_size = size_stored;
                    end else begin
                        m.data_offset = {1'b0, start_eff};
                        m.packed_size = room_grp;
                        m.skip_size   = skip_eff;
                    end
                    rs.slot[0] = m;
                    n = 2'd1;
                    grp_open_next  = 1'b1;
                    grp_start_next = start_eff;
                    grp_skip_next  = skip_eff + {16'd0, f_orig[30:0]};
                    grp_first_next = first_eff;
                    if (((f_flags & FLAG_END_GROUP) != 8'd0) && !stored_mode_reg) begin
                        rs.slot[1] = blank(KIND_CLOSE, done_reg);
                        rs.slot[1].data_offset = {1'b0, start_eff};
                        rs.slot[1].packed_size = size_close;
                        rs.slot[1].group_first = first_eff;
                        n = 2'd2;
                        grp_open_next = 1'b0;
                    end
                    done_next = done_inc;
                    pos_next  = '0;
                    if (done_inc >= member_count_reg || item.last_byte) begin
                        rs.slot[n] = status(1'b0, done_inc);
                        n = n + 2'd1;
                        phase_next = PH_DONE;
                    end else begin
                        phase_next = PH_RECORD;
                    end
                end
            end
            PH_DONE: begin
                n = 2'd0;
            end
            default: begin
                n = 2'd0;
            end
        endcase

        if (n != 2'd0) begin
            rs.slot[n - 2'd1].last_of_run = 1'b1;
        end
        rs.count = n;
        res_set  = rs;
    end

    assign take = item_valid && (res_set.count == 2'd0 || out_free);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            member_count_reg <= 16'd1;
            input_size_reg   <= 32'd0;
            stored_mode_reg  <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_MEMBER_COUNT: member_count_reg <= cfg_data[15:0];
                CFG_INPUT_SIZE:   input_size_reg   <= cfg_data;
                CFG_STORED_MODE:  stored_mode_reg  <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_RECORD;
            pos_reg       <= '0;
            name_len_reg  <= '0;
            done_reg      <= 16'd0;
            grp_open_reg  <= 1'b0;
            grp_start_reg <= 31'd0;
            grp_skip_reg  <= 47'd0;
            grp_first_reg <= 16'd0;
        end else if (take) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            name_len_reg  <= name_len_next;
            done_reg      <= done_next;
            grp_open_reg  <= grp_open_next;
            grp_start_reg <= grp_start_next;
            grp_skip_reg  <= grp_skip_next;
            grp_first_reg <= grp_first_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && rec_we) begin
            rec_reg[pos_reg] <= item.dir_byte;
        end
    end

endmodule

// File: hdl/adrp_out_buf.sv
// Result register that hands out the results of one byte, one per beat.
module adrp_out_buf (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               load,
    input  adrp_pkg::res_set_t res_set,
    output logic               out_free,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [231:0]       m_tdata,
    output logic [2:0]         m_tuser,
    output logic               m_tlast
);
    import adrp_pkg::*;

    result_t    slot_reg [SLOT_COUNT];
    logic [1:0] cnt_reg;
    logic [1:0] ptr_reg;
    logic       at_end;
    result_t    cur;

    assign cur      = slot_reg[ptr_reg];
    assign m_tvalid = cnt_reg != 2'd0;
    assign at_end   = ptr_reg == cnt_reg - 2'd1;
    assign out_free = (cnt_reg == 2'd0) || (m_tready && at_end);

    assign m_tuser = cur.kind;
    assign m_tlast = cur.last_of_run;
    assign m_tdata = {2'b00, cur.member_total, cur.group_first, cur.timestamp,
                      cur.original_size, cur.skip_size, cur.packed_size,
                      cur.data_offset, cur.name_char, cur.member_index};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 2'd0;
            ptr_reg <= 2'd0;
        end else if (load) begin
            cnt_reg <= res_set.count;
            ptr_reg <= 2'd0;
        end else if (m_tvalid && m_tready) begin
            if (at_end) begin
                cnt_reg <= 2'd0;
                ptr_reg <= 2'd0;
            end else begin
                ptr_reg <= ptr_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            for (int i = 0; i < SLOT_COUNT; i++) begin
                slot_reg[i] <= res_set.slot[i];
            end
        end
    end

endmodule

// File: hdl/archive_directory_record_parser.sv
// Top level of the archive directory record parser.
//
//  Channel   Direction  Beat contents
//  s_*       in         tdata[7:0] directory byte, tlast final byte of the directory
//  m_*       out        tuser result kind, tdata result fields, tlast last result of a byte
//  cfg_*     in         write enable, register index, write data
//
// Each accepted byte is held in an input register, handled by the parser
// logic combinationally, and its results land in a result register. A
// byte that causes two or three results (name end with status, member
// with group close and status) holds the result register for that many
// output beats, so the output port sets the rate. Reset is synchronous
// and active low; the first byte can be taken in the cycle after aresetn
// rises. A stall on m_tready backs up into s_tready once both registers
// are full.
module archive_directory_record_parser #(
    parameter int NAME_LIMIT = 1024
) (
    input  logic         aclk,
    input  logic         aresetn,
    // Directory bytes in.
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // [7:0] dir_byte
    input  logic         s_tlast,   // last_byte
    // Results out.
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [231:0] m_tdata,   // member_index, name_char, data_offset, packed_size,
                                    // skip_size, original_size, timestamp, group_first,
                                    // member_total, then two zero bits
    output logic [2:0]   m_tuser,   // [2:0] kind
    output logic         m_tlast,   // last_of_run
    // Configuration writes.
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);
    import adrp_pkg::*;

    logic     take;
    logic     item_valid;
    item_t    item;
    logic     out_free;
    res_set_t res_set;

    // Input register: one directory byte waits here for the parser.
    adrp_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    // Parser state and the combinational handling of the held byte. The
    // byte is consumed when it causes no result or the result register
    // frees up in this cycle.
    adrp_core #(
        .NAME_LIMIT (NAME_LIMIT)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .item_valid (item_valid),
        .item       (item),
        .out_free   (out_free),
        .take       (take),
        .res_set    (res_set)
    );

    // Result register: up to three results of one byte, sent in order.
    adrp_out_buf u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (take && res_set.count != 2'd0),
        .res_set  (res_set),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
